/* rtl/lcdt_pkg.sv */
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and constants for the LCD mode timing controller.
// ----------------------------------------------------------------------------
package lcdt_pkg;

    localparam int unsigned DOT_W  = 16;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned ADD_W  = 8;
    localparam int unsigned EN_W   = 4;
    localparam int unsigned CFG_W  = 8;
    localparam int unsigned CFG_AW = 2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [DOT_W-1:0] DOTS_OAM    = DOT_W'(80);
    localparam logic [DOT_W-1:0] DOTS_DRAW   = DOT_W'(172);
    localparam logic [DOT_W-1:0] DOTS_HBLANK = DOT_W'(204);
    localparam logic [DOT_W-1:0] DOTS_LINE   = DOT_W'(456);

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
    localparam logic [LINE_W-1:0] LAST_LINE         = LINE_W'(153);

    localparam int unsigned EN_HBLANK_BIT = 0;
    localparam int unsigned EN_VBLANK_BIT = 1;
    localparam int unsigned EN_OAM_BIT    = 2;
    localparam int unsigned EN_LYC_BIT    = 3;

    localparam logic [CFG_AW-1:0] CFG_STAT_EN  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LINE_CMP = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WIN_TOP  = 2'd2;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [EN_W-1:0]   stat_en;
        logic [LINE_W-1:0] line_cmp;
        logic [LINE_W-1:0] win_top;
    } t_cfg;

    typedef struct packed {
        logic [DOT_W-1:0]  dot_count;
        logic [LINE_W-1:0] line_count;
        logic [1:0]        ppu_mode;
        logic              coincidence;
        logic              window_flag;
        logic              was_disabled;
    } t_state;

    typedef struct packed {
        logic              window_active;
        logic              frame_done;
        logic              line_render;
        logic              oam_scan_start;
        logic              stat_irq;
        logic              vblank_irq;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic [1:0]        mode;
    } t_result;

endpackage

/* rtl/lcdt_step.sv */
// ----------------------------------------------------------------------------
// lcdt_step
// Next-state and result logic for one word of elapsed dots.
// ----------------------------------------------------------------------------
module lcdt_step (
    input  lcdt_pkg::t_cfg                    i_cfg,
    input  lcdt_pkg::t_state                  i_state,
    input  logic                              i_display_on,
    input  logic [lcdt_pkg::ADD_W-1:0]        i_cycles_added,
    output lcdt_pkg::t_state                  o_state,
    output lcdt_pkg::t_result                 o_result
);
    import lcdt_pkg::*;

    logic [DOT_W-1:0]  base_dot;
    logic [LINE_W-1:0] base_line;
    logic              base_win;
    logic [DOT_W:0]    dot_sum;
    logic [DOT_W-1:0]  dot_sat;
    logic [LINE_W-1:0] line_inc;
    logic              allow;
    t_state            ns;
    logic              vb_irq;
    logic              st_irq;
    logic              scan;
    logic              render;
    logic              frame;

    assign base_dot  = i_state.was_disabled ? '0 : i_state.dot_count;
    assign base_line = i_state.was_disabled ? '0 : i_state.line_count;
    assign base_win  = i_state.was_disabled ? 1'b0 : i_state.window_flag;
    assign dot_sum   = {1'b0, base_dot} + {{(DOT_W + 1 - ADD_W){1'b0}}, i_cycles_added};
    assign dot_sat   = dot_sum[DOT_W] ? '1 : dot_sum[DOT_W-1:0];
    assign line_inc  = base_line + LINE_W'(1);

    assign allow = !((i_cfg.stat_en[EN_LYC_BIT] && i_state.coincidence)
                  || (i_cfg.stat_en[EN_OAM_BIT] && i_state.ppu_mode == MODE_OAM)
                  || (i_cfg.stat_en[EN_VBLANK_BIT] && i_state.ppu_mode == MODE_VBLANK)
                  || (i_cfg.stat_en[EN_HBLANK_BIT] && i_state.ppu_mode == MODE_HBLANK));

    always_comb begin
        ns     = i_state;
        vb_irq = 1'b0;
        st_irq = 1'b0;
        scan   = 1'b0;
        render = 1'b0;
        frame  = 1'b0;
        if (!i_display_on) begin
            ns.ppu_mode     = MODE_HBLANK;
            ns.was_disabled = 1'b1;
        end else begin
            ns.was_disabled = 1'b0;
            ns.dot_count    = dot_sat;
            ns.line_count   = base_line;
            ns.window_flag  = base_win;
            case (i_state.ppu_mode)
                MODE_HBLANK: begin
                    if (dot_sat >= DOTS_HBLANK) begin
                        ns.dot_count  = dot_sat - DOTS_HBLANK;
                        ns.line_count = line_inc;
                        if (line_inc == FIRST_VBLANK_LINE) begin
                            ns.ppu_mode = MODE_VBLANK;
                            vb_irq      = 1'b1;
                            st_irq      = i_cfg.stat_en[EN_VBLANK_BIT] && allow;
                        end else begin
                            ns.ppu_mode = MODE_OAM;
                            st_irq      = i_cfg.stat_en[EN_OAM_BIT] && allow;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (dot_sat >= DOTS_LINE) begin
                        ns.dot_count  = dot_sat - DOTS_LINE;
                        ns.line_count = line_inc;
                        if (line_inc > LAST_LINE) begin
                            frame          = 1'b1;
                            ns.ppu_mode    = MODE_OAM;
                            st_irq         = i_cfg.stat_en[EN_OAM_BIT] && allow;
                            ns.line_count  = '0;
                            ns.window_flag = 1'b0;
                        end
                    end
                end
                MODE_OAM: begin
                    if (dot_sat >= DOTS_OAM) begin
                        scan         = 1'b1;
                        ns.dot_count = dot_sat - DOTS_OAM;
                        ns.ppu_mode  = MODE_DRAW;
                    end
                end
                default: begin
                    if (dot_sat >= DOTS_DRAW) begin
                        ns.dot_count = dot_sat - DOTS_DRAW;
                        ns.ppu_mode  = MODE_HBLANK;
                        st_irq       = i_cfg.stat_en[EN_HBLANK_BIT] && allow;
                        render       = 1'b1;
                    end
                end
            endcase
            ns.coincidence = (ns.line_count == i_cfg.line_cmp);
            if (ns.coincidence && i_cfg.stat_en[EN_LYC_BIT] && allow) begin
                st_irq = 1'b1;
            end
            if (i_cfg.win_top == ns.line_count) begin
                ns.window_flag = 1'b1;
            end
        end
    end

    assign o_state                 = ns;
    assign o_result.mode           = ns.ppu_mode;
    assign o_result.coincidence    = ns.coincidence;
    assign o_result.line           = ns.line_count;
    assign o_result.vblank_irq     = vb_irq;
    assign o_result.stat_irq       = st_irq;
    assign o_result.oam_scan_start = scan;
    assign o_result.line_render    = render;
    assign o_result.frame_done     = frame;
    assign o_result.window_active  = ns.window_flag;

endmodule

/* rtl/lcd_mode_timing_controller.sv */
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller
// Dot, line and mode sequencer with vblank and STAT interrupt requests.
// ----------------------------------------------------------------------------
// Each input word carries the display enable and the dots elapsed since the
// previous word; each accepted word yields exactly one result word. One word
// is taken every cycle unless the skid is full: the step unit updates the
// dot/line/mode state on accept, and a two-entry output buffer keeps
// s_axis_tready high while one result waits. The user must write registers
// through the cfg port only while no result is pending; it is not enforced.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lcdt_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [lcdt_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] display_on, [8:1] cycles_added, [15:9] zero
    input  logic [lcdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] mode, [2] coincidence, [10:3] line, [11] vblank_irq, [12] stat_irq,
    // [13] oam_scan_start, [14] line_render, [15] frame_done,
    // [16] window_active, [23:17] zero
    output logic [lcdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lcdt_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    push;
    logic    pop;

    assign s_axis_tready = !r_skid_valid;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    lcdt_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_display_on   (s_axis_tdata[0]),
        .i_cycles_added (s_axis_tdata[ADD_W:1]),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_STAT_EN:  r_cfg.stat_en  <= i_cfg_wdata[EN_W-1:0];
                CFG_LINE_CMP: r_cfg.line_cmp <= i_cfg_wdata[LINE_W-1:0];
                CFG_WIN_TOP:  r_cfg.win_top  <= i_cfg_wdata[LINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (push) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (push) begin
                    r_out <= n_result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (push) begin
                if (r_out_valid) begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out       <= n_result;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without head entry");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_count <= LAST_LINE)
        else $error("line counter beyond last line");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> (r_out.line == '0 && r_out.mode == MODE_OAM))
        else $error("frame done without restart at line zero");

    a_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.vblank_irq)
            |-> (r_out.line == FIRST_VBLANK_LINE && r_out.mode == MODE_VBLANK))
        else $error("vblank request outside vblank entry");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_axis_tready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost while stalled");

endmodule

/* tb/sv/lcd_mode_timing_controller_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_controller_tb
// Self-checking bench for the LCD mode timing controller.
// ----------------------------------------------------------------------------
// Drives elapsed-dot words into the slave stream and predicts each status word
// with an in-bench model of the dot, line and mode sequencer. Status words
// from the master stream are compared in order against the predictions. Both
// sides idle and stall at random; register settings change between phases.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_tb;
    import lcdt_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr    = '0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [EN_W-1:0]   cfg_stat_en  = '0;
    logic [LINE_W-1:0] cfg_line_cmp = '0;
    logic [LINE_W-1:0] cfg_win_top  = '0;

    logic [DOT_W-1:0]  pr_dots = '0;
    logic [LINE_W-1:0] pr_line = '0;
    logic [1:0]        pr_mode = MODE_HBLANK;
    logic              pr_coin = 1'b0;
    logic              pr_win  = 1'b0;
    logic              pr_off  = 1'b0;

    t_result     pending_status[$];
    int unsigned mismatch_cnt = 0;
    int unsigned stall_left   = 0;
    bit          tx_idle_en   = 1'b1;
    bit          rx_idle_en   = 1'b1;

    lcd_mode_timing_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result predict_timing(input logic on, input logic [ADD_W-1:0] add);
        t_result     r;
        logic        allow;
        logic        vb;
        logic        st;
        logic        scan;
        logic        rend;
        logic        frm;
        int unsigned dots;
        vb   = 1'b0;
        st   = 1'b0;
        scan = 1'b0;
        rend = 1'b0;
        frm  = 1'b0;
        if (!on) begin
            pr_mode = MODE_HBLANK;
            pr_off  = 1'b1;
        end else begin
            if (pr_off) begin
                pr_win  = 1'b0;
                pr_dots = '0;
                pr_line = '0;
                pr_off  = 1'b0;
            end
            dots = pr_dots + add;
            if (dots > 65535) dots = 65535;
            pr_dots = dots[DOT_W-1:0];
            allow = !((cfg_stat_en[EN_LYC_BIT] && pr_coin) ||
                      (cfg_stat_en[EN_OAM_BIT] && pr_mode == MODE_OAM) ||
                      (cfg_stat_en[EN_VBLANK_BIT] && pr_mode == MODE_VBLANK) ||
                      (cfg_stat_en[EN_HBLANK_BIT] && pr_mode == MODE_HBLANK));
            case (pr_mode)
                MODE_HBLANK: begin
                    if (pr_dots >= DOTS_HBLANK) begin
                        pr_dots = pr_dots - DOTS_HBLANK;
                        pr_line = pr_line + 1'b1;
                        if (pr_line == FIRST_VBLANK_LINE) begin
                            pr_mode = MODE_VBLANK;
                            vb      = 1'b1;
                            if (cfg_stat_en[EN_VBLANK_BIT] && allow) st = 1'b1;
                        end else begin
                            pr_mode = MODE_OAM;
                            if (cfg_stat_en[EN_OAM_BIT] && allow) st = 1'b1;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (pr_dots >= DOTS_LINE) begin
                        pr_dots = pr_dots - DOTS_LINE;
                        pr_line = pr_line + 1'b1;
                        if (pr_line > LAST_LINE) begin
                            frm     = 1'b1;
                            pr_mode = MODE_OAM;
                            if (cfg_stat_en[EN_OAM_BIT] && allow) st = 1'b1;
                            pr_line = '0;
                            pr_win  = 1'b0;
                        end
                    end
                end
                MODE_OAM: begin
                    if (pr_dots >= DOTS_OAM) begin
                        scan    = 1'b1;
                        pr_dots = pr_dots - DOTS_OAM;
                        pr_mode = MODE_DRAW;
                    end
                end
                default: begin
                    if (pr_dots >= DOTS_DRAW) begin
                        pr_dots = pr_dots - DOTS_DRAW;
                        pr_mode = MODE_HBLANK;
                        if (cfg_stat_en[EN_HBLANK_BIT] && allow) st = 1'b1;
                        rend = 1'b1;
                    end
                end
            endcase
            pr_coin = (pr_line == cfg_line_cmp);
            if (pr_coin && cfg_stat_en[EN_LYC_BIT] && allow) st = 1'b1;
            if (cfg_win_top == pr_line) pr_win = 1'b1;
        end
        r.mode           = pr_mode;
        r.coincidence    = pr_coin;
        r.line           = pr_line;
        r.vblank_irq     = vb;
        r.stat_irq       = st;
        r.oam_scan_start = scan;
        r.line_render    = rend;
        r.frame_done     = frm;
        r.window_active  = pr_win;
        return r;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_word(input logic on, input logic [ADD_W-1:0] add);
        int unsigned gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 30) gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, add, on};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_status.push_back(predict_timing(on, add));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_STAT_EN:  cfg_stat_en  = val[EN_W-1:0];
            CFG_LINE_CMP: cfg_line_cmp = val[LINE_W-1:0];
            CFG_WIN_TOP:  cfg_win_top  = val[LINE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [EN_W-1:0] stat_en, input logic [LINE_W-1:0] cmp,
                                input logic [LINE_W-1:0] win);
        wait_idle();
        write_reg(CFG_STAT_EN, CFG_W'(stat_en));
        write_reg(CFG_LINE_CMP, cmp);
        write_reg(CFG_WIN_TOP, win);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n, input int unsigned off_pct,
                              input int unsigned hi_pct, input int unsigned drain_at);
        logic             on;
        logic [ADD_W-1:0] add;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (drain_at != 0 && i == drain_at) wait_idle();
            on = ($urandom_range(0, 99) >= off_pct);
            if ($urandom_range(0, 99) < hi_pct) begin
                add = ($urandom_range(0, 3) == 0) ? 8'd255 : ADD_W'($urandom_range(152, 255));
            end else begin
                add = ADD_W'($urandom_range(0, 255));
            end
            send_word(on, add);
        end
    endtask

    task automatic test_directed();
        logic [ADD_W:0] seq[$];
        seq = '{{8'd0, 1'b1}, {8'd255, 1'b1}, {8'd255, 1'b1}, {8'd255, 1'b1},
                {8'd255, 1'b1}, {8'd255, 1'b0}, {8'd0, 1'b0}, {8'd204, 1'b1},
                {8'd80, 1'b1}, {8'd172, 1'b1}, {8'd204, 1'b1}, {8'd79, 1'b1},
                {8'd1, 1'b1}, {8'd171, 1'b1}, {8'd1, 1'b1}, {8'd203, 1'b1},
                {8'd1, 1'b1}, {8'd1, 1'b0}, {8'd255, 1'b1}, {8'd255, 1'b1},
                {8'd255, 1'b1}, {8'd255, 1'b1}};
        apply_config(4'hF, 8'd1, 8'd2);
        foreach (seq[i]) send_word(seq[i][0], seq[i][ADD_W:1]);
    endtask

    task automatic test_random_mixed();
        apply_config(EN_W'($urandom_range(0, 15)), LINE_W'($urandom_range(0, 20)),
                     LINE_W'($urandom_range(0, 20)));
        run_random(100, 5, 50, 50);
    endtask

    // Hold the display on with mostly full dot bursts: full frames, then random bursts.
    task automatic test_full_frames();
        apply_config(4'hF, LAST_LINE, 8'd0);
        send_word(1'b0, 8'd0);
        repeat (700) send_word(1'b1, 8'd255);
        run_random(80, 0, 95, 0);
    endtask

    task automatic test_irq_disabled();
        apply_config(4'h0, 8'd255, 8'd255);
        run_random(100, 3, 60, 0);
    endtask

    task automatic test_random_cfg();
        apply_config(EN_W'($urandom_range(0, 15)), 8'd0, LINE_W'($urandom_range(0, 255)));
        run_random(50, 10, 40, 0);
        apply_config(EN_W'($urandom_range(0, 15)), LINE_W'($urandom_range(0, 255)),
                     LINE_W'($urandom_range(0, 8)));
        run_random(50, 10, 40, 25);
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 99) < 20) stall_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        t_result act;
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_status.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected status word %h", m_axis_tdata);
            end else begin
                exp_r = pending_status.pop_front();
                if (act !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch exp/act: mode %0d/%0d coin %0b/%0b line %0d/%0d",
                                 exp_r.mode, act.mode, exp_r.coincidence, act.coincidence,
                                 exp_r.line, act.line);
                        $display("  vb %0b/%0b st %0b/%0b scan %0b/%0b rend %0b/%0b",
                                 exp_r.vblank_irq, act.vblank_irq, exp_r.stat_irq,
                                 act.stat_irq, exp_r.oam_scan_start, act.oam_scan_start,
                                 exp_r.line_render, act.line_render);
                        $display("  frame %0b/%0b win %0b/%0b",
                                 exp_r.frame_done, act.frame_done,
                                 exp_r.window_active, act.window_active);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned idle_cnt;
        idle_cnt = 0;
        while (idle_cnt < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mixed();
        test_full_frames();
        test_irq_disabled();
        test_random_cfg();
        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
